// ===== sv/cce_pkg.sv =====
// Shared definitions for the COBS/CRC-16 frame encoder.
// Holds default sizes, opcode and byte-select codes, the command and status
// structs between controller and datapath, and the CRC byte update.
package cce_pkg;

  localparam int BUF_DEPTH_DEF   = 256;
  localparam int MAX_PAYLOAD_DEF = 250;

  // Slots that must remain free for a payload byte plus the CRC trailer.
  localparam int CRC_RESERVE = 5;

  localparam logic [15:0] CRC_POLY      = 16'h1021;
  localparam logic [15:0] CRC_SEED_INIT = 16'hFFFF;
  localparam logic [7:0]  CODE_MAX      = 8'hFF;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Which byte the encoder takes in.
  localparam logic [1:0] SEL_DATA   = 2'd0;
  localparam logic [1:0] SEL_CRC_LO = 2'd1;
  localparam logic [1:0] SEL_CRC_HI = 2'd2;

  typedef struct packed {
    logic       push;      // a payload word is accepted
    logic       read;      // a read word is accepted
    logic       enc;       // encode the selected byte
    logic       fill;      // write back a full group's code byte
    logic       close;     // write the last code byte, frame is ready
    logic [1:0] sel;       // byte select for enc
    logic       out_load;  // move the pending result to the output register
  } cmd_t;

  typedef struct packed {
    logic frame_ready;
    logic take;       // the next payload byte fits
    logic fill_need;  // the byte being encoded fills its group
    logic out_free;   // the output register can be loaded this cycle
  } sts_t;

  // One byte through CRC-16/CCITT, MSB first.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc,
                                             input logic [7:0]  b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

// ===== sv/cobs_crc16_frame_encoder.sv =====
// COBS frame encoder with a CRC-16/CCITT trailer, top level.
// Joins the controller (cce_ctrl) and the datapath (cce_datapath); uses cce_pkg.
//
// Usage. Words arrive on the input channel (in_valid/in_ready) carrying
// opcode, data_byte and final_byte. A push word (opcode 0) adds a payload byte
// to the frame being built: the CRC is updated and the byte is COBS-encoded
// into the frame buffer at once. The push carrying final_byte also encodes the
// CRC, low byte first, and closes the last group, which makes the frame ready.
// Pushes while a ready frame is still being drained are dropped silently.
// A read word (opcode 1) yields exactly one result word on the output channel
// (out_valid/out_ready): the next encoded byte, then the 0x00 delimiter with
// frame_end set, after which the encoder starts a new frame. With no frame
// ready the result has status set and all other fields zero.
// Timing. A push encodes its byte and, when that byte fills a 254-byte group,
// writes back the code byte; an ignored push or a dropped byte ends there. A
// final push then encodes the CRC bytes and closes the group in turn, since
// every buffer write (data byte or code byte written back) uses the single
// write port of the frame buffer. A read reads the buffer, then loads the
// output register; if the receiver stalls, it waits until the register frees
// and no word is taken meanwhile. Pushes are accepted behind a pending result.
// Reset empties the encoder, sets the CRC seed to 0xFFFF and needs no clearing
// pass. The seed (cfg_we/cfg_wdata) takes effect at a frame's first byte.
module cobs_crc16_frame_encoder #(
  parameter int BUF_DEPTH   = cce_pkg::BUF_DEPTH_DEF,
  parameter int MAX_PAYLOAD = cce_pkg::MAX_PAYLOAD_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        opcode,
  input  logic [7:0]  data_byte,
  input  logic        final_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        frame_end,
  output logic        status,
  output logic        overflow,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  cce_pkg::cmd_t cmd;
  cce_pkg::sts_t sts;

  // The controller only issues commands; all frame state lives in the datapath.
  cce_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .opcode     (opcode),
    .final_byte (final_byte),
    .sts        (sts),
    .cmd        (cmd)
  );

  cce_datapath #(
    .BUF_DEPTH   (BUF_DEPTH),
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .data_byte (data_byte),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .frame_end (frame_end),
    .status    (status),
    .overflow  (overflow)
  );

endmodule

// ===== sv/cce_ctrl.sv =====
// Controller of the COBS/CRC-16 frame encoder.
// Sequences accepted words into datapath commands; uses cce_pkg.
module cce_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          opcode,
  input  logic          final_byte,
  input  cce_pkg::sts_t sts,
  output cce_pkg::cmd_t cmd
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_ENC    = 3'd1;
  localparam logic [2:0] ST_FILL   = 3'd2;
  localparam logic [2:0] ST_CLOSE  = 3'd3;
  localparam logic [2:0] ST_RD_OUT = 3'd4;

  logic [2:0] state, state_next;
  logic [1:0] sel, sel_next;
  logic       fin, fin_next;
  logic [2:0] adv_state;
  logic [1:0] adv_sel;

  // Where to go once the current byte (and any code write-back) is done.
  always_comb begin
    adv_state = ST_IDLE;
    adv_sel   = sel;
    case (sel)
      cce_pkg::SEL_DATA: begin
        if (fin) begin
          adv_state = ST_ENC;
          adv_sel   = cce_pkg::SEL_CRC_LO;
        end
      end
      cce_pkg::SEL_CRC_LO: begin
        adv_state = ST_ENC;
        adv_sel   = cce_pkg::SEL_CRC_HI;
      end
      cce_pkg::SEL_CRC_HI: begin
        adv_state = ST_CLOSE;
      end
      default: begin
        adv_state = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    sel_next   = sel;
    fin_next   = fin;
    in_ready   = 1'b0;
    cmd        = '0;
    cmd.sel    = sel;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (opcode == cce_pkg::OP_READ) begin
            cmd.read   = 1'b1;
            state_next = ST_RD_OUT;
          end else if (!sts.frame_ready) begin
            cmd.push = 1'b1;
            fin_next = final_byte;
            if (sts.take) begin
              sel_next   = cce_pkg::SEL_DATA;
              state_next = ST_ENC;
            end else if (final_byte) begin
              sel_next   = cce_pkg::SEL_CRC_LO;
              state_next = ST_ENC;
            end
          end
        end
      end
      ST_ENC: begin
        cmd.enc = 1'b1;
        if (sts.fill_need) begin
          state_next = ST_FILL;
        end else begin
          state_next = adv_state;
          sel_next   = adv_sel;
        end
      end
      ST_FILL: begin
        cmd.fill   = 1'b1;
        state_next = adv_state;
        sel_next   = adv_sel;
      end
      ST_CLOSE: begin
        cmd.close  = 1'b1;
        state_next = ST_IDLE;
      end
      ST_RD_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      sel   <= cce_pkg::SEL_DATA;
      fin   <= 1'b0;
    end else begin
      state <= state_next;
      sel   <= sel_next;
      fin   <= fin_next;
    end
  end

endmodule

// ===== sv/cce_datapath.sv =====
// Datapath of the COBS/CRC-16 frame encoder: frame buffer, CRC register,
// encoder pointers and the output register. Uses cce_pkg.
module cce_datapath #(
  parameter int BUF_DEPTH   = cce_pkg::BUF_DEPTH_DEF,
  parameter int MAX_PAYLOAD = cce_pkg::MAX_PAYLOAD_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  cce_pkg::cmd_t cmd,
  output cce_pkg::sts_t sts,
  input  logic [7:0]    data_byte,
  input  logic          cfg_we,
  input  logic [15:0]   cfg_wdata,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_byte,
  output logic          frame_end,
  output logic          status,
  output logic          overflow
);

  localparam int AW = $clog2(BUF_DEPTH);
  localparam int PW = $clog2(BUF_DEPTH + 1);
  localparam int CW = $clog2(MAX_PAYLOAD + 1);
  localparam logic [PW:0]   ROOM_LIMIT = (PW + 1)'(BUF_DEPTH);
  localparam logic [PW:0]   RESERVE    = (PW + 1)'(cce_pkg::CRC_RESERVE);
  localparam logic [PW-1:0] DEPTH_P    = PW'(BUF_DEPTH);
  localparam logic [CW-1:0] COUNT_MAX  = CW'(MAX_PAYLOAD);

  logic [7:0]    mem [BUF_DEPTH];
  logic [7:0]    mem_q;

  logic [15:0]   crc_seed;
  logic [15:0]   crc_reg;
  logic [PW-1:0] write_pos;
  logic [PW-1:0] code_pos;
  logic [7:0]    group_code;
  logic [CW-1:0] payload_count;
  logic [PW-1:0] read_pos;
  logic          frame_ready;
  logic          overflow_flag;
  logic [7:0]    data_reg;

  logic          pend_data;
  logic          pend_end;
  logic          pend_status;
  logic          pend_ovf;

  logic          seed_load;
  logic [15:0]   crc_start;
  logic          take;
  logic [7:0]    enc_byte;
  logic [PW-1:0] wp_inc;
  logic          rd_avail;
  logic          mem_we;
  logic [PW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;

  assign seed_load = (payload_count == '0) && !overflow_flag;
  assign crc_start = seed_load ? crc_seed : crc_reg;
  assign take      = (payload_count < COUNT_MAX) &&
                     (({1'b0, write_pos} + RESERVE) <= ROOM_LIMIT);
  assign wp_inc    = (write_pos < DEPTH_P) ? write_pos + PW'(1) : write_pos;
  assign rd_avail  = frame_ready && (read_pos < write_pos) && (read_pos < DEPTH_P);

  always_comb begin
    case (cmd.sel)
      cce_pkg::SEL_CRC_LO: enc_byte = crc_reg[7:0];
      cce_pkg::SEL_CRC_HI: enc_byte = crc_reg[15:8];
      default:             enc_byte = data_reg;
    endcase
  end

  // One buffer write per cycle: a data byte or a code byte written back.
  always_comb begin
    mem_waddr = code_pos;
    mem_wdata = group_code;
    if (cmd.enc && enc_byte != 8'h00) begin
      mem_waddr = write_pos;
      mem_wdata = enc_byte;
    end else if (cmd.fill) begin
      mem_wdata = cce_pkg::CODE_MAX;
    end
    mem_we = (cmd.enc || cmd.fill || cmd.close) && (mem_waddr < DEPTH_P);
  end

  assign sts.frame_ready = frame_ready;
  assign sts.take        = take;
  assign sts.fill_need   = (enc_byte != 8'h00) &&
                           (group_code == cce_pkg::CODE_MAX - 8'd1);
  assign sts.out_free    = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr[AW-1:0]] <= mem_wdata;
    end
    if (cmd.read && rd_avail) begin
      mem_q <= mem[read_pos[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push && take) begin
      data_reg <= data_byte;
    end
    if (cmd.out_load) begin
      out_byte  <= pend_data ? mem_q : 8'h00;
      frame_end <= pend_end;
      status    <= pend_status;
      overflow  <= pend_ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_seed      <= cce_pkg::CRC_SEED_INIT;
      crc_reg       <= cce_pkg::CRC_SEED_INIT;
      write_pos     <= PW'(1);
      code_pos      <= '0;
      group_code    <= 8'd1;
      payload_count <= '0;
      read_pos      <= '0;
      frame_ready   <= 1'b0;
      overflow_flag <= 1'b0;
      pend_data     <= 1'b0;
      pend_end      <= 1'b0;
      pend_status   <= 1'b0;
      pend_ovf      <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        crc_seed <= cfg_wdata;
      end
      out_valid <= cmd.out_load || (out_valid && !out_ready);

      if (cmd.push) begin
        if (take) begin
          crc_reg       <= cce_pkg::crc16_byte(crc_start, data_byte);
          payload_count <= payload_count + CW'(1);
        end else begin
          overflow_flag <= 1'b1;
          if (seed_load) begin
            crc_reg <= crc_seed;
          end
        end
      end

      if (cmd.enc) begin
        write_pos <= wp_inc;
        if (enc_byte == 8'h00) begin
          code_pos   <= write_pos;
          group_code <= 8'd1;
        end else begin
          group_code <= group_code + 8'd1;
        end
      end

      if (cmd.fill) begin
        code_pos   <= write_pos;
        write_pos  <= wp_inc;
        group_code <= 8'd1;
      end

      if (cmd.close) begin
        frame_ready <= 1'b1;
        read_pos    <= '0;
      end

      if (cmd.read) begin
        pend_status <= !frame_ready;
        pend_ovf    <= frame_ready && overflow_flag;
        pend_data   <= rd_avail;
        pend_end    <= frame_ready && !rd_avail;
        if (rd_avail) begin
          read_pos <= read_pos + PW'(1);
        end else if (frame_ready) begin
          // Delimiter read: start a fresh frame.
          write_pos     <= PW'(1);
          code_pos      <= '0;
          group_code    <= 8'd1;
          crc_reg       <= crc_seed;
          payload_count <= '0;
          read_pos      <= '0;
          frame_ready   <= 1'b0;
          overflow_flag <= 1'b0;
        end
      end
    end
  end

endmodule

// ===== sv/cce_checker.sv =====
// Port-level checks for the COBS/CRC-16 frame encoder, bound to its top level.
// Uses cce_pkg for the opcode codes.
module cce_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       opcode,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       frame_end,
  input logic       status,
  input logic       overflow
);

  // A result saying no frame is ready carries nothing else.
  a_status_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> out_byte == 8'h00 && !frame_end && !overflow)
    else $error("status word carries data");

  // The delimiter is always zero and belongs to a ready frame.
  a_delim_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_end |-> out_byte == 8'h00 && !status)
    else $error("bad delimiter word");

  // A read occupies the block for its result cycle.
  a_read_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && opcode == cce_pkg::OP_READ |=> !in_ready)
    else $error("read word did not occupy the block");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(frame_end))
    else $error("stalled result changed");

endmodule

bind cobs_crc16_frame_encoder cce_checker u_cce_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .opcode    (opcode),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_byte  (out_byte),
  .frame_end (frame_end),
  .status    (status),
  .overflow  (overflow)
);
